>>> src/vigenere_xor_byte_cipher_unit_macros.svh
// Assertion helpers shared by the checker.
`ifndef VIGENERE_XOR_BYTE_CIPHER_UNIT_MACROS_SVH
`define VIGENERE_XOR_BYTE_CIPHER_UNIT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define VXC_ASSERT(lbl, clk_i, rst_n_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define VXC_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/vxc_pkg.sv
package vxc_pkg;

	localparam int KEY_BYTES_DEF = 16;
	localparam int KEY_W         = 128;
	localparam int ADDR_W        = 6;
	localparam int DATA_W        = 64;

	// register indexes (byte address = 8 * index)
	localparam logic [2:0] REG_KEY_LO  = 3'd0;
	localparam logic [2:0] REG_KEY_HI  = 3'd1;
	localparam logic [2:0] REG_KEY_LEN = 3'd2;
	localparam logic [2:0] REG_CAESAR  = 3'd3;
	localparam logic [2:0] REG_XOR     = 3'd4;
	localparam logic [2:0] REG_DECRYPT = 3'd5;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0] EOF_BYTE     = 8'hFF;

	localparam logic signed [9:0] LANG_FIRST = 10'sd32;
	localparam logic signed [9:0] LANG_MOD   = 10'sd95;   // span 94 plus one

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [4:0]       key_length;
		logic             caesar_en;
		logic             xor_en;
		logic             decrypt;
	} cfg_t;

	typedef struct packed {
		logic [3:0] shift_pos;
		logic [3:0] xor_pos;
	} key_pos_t;

	// ((p-32)+(k-32)) rem 95 + 32, truncating remainder, signed bytes
	function automatic logic [7:0] shift_enc(input logic [7:0] p, input logic [7:0] k);
		logic signed [9:0] s;
		logic signed [9:0] r;
		s = $signed({{2{p[7]}}, p}) + $signed({{2{k[7]}}, k}) - (LANG_FIRST + LANG_FIRST);
		if (s >= LANG_MOD + LANG_MOD)
			r = s - (LANG_MOD + LANG_MOD);
		else if (s >= LANG_MOD)
			r = s - LANG_MOD;
		else if (s <= -(LANG_MOD * 10'sd3))
			r = s + LANG_MOD * 10'sd3;
		else if (s <= -(LANG_MOD + LANG_MOD))
			r = s + (LANG_MOD + LANG_MOD);
		else if (s <= -LANG_MOD)
			r = s + LANG_MOD;
		else
			r = s;
		r = r + LANG_FIRST;
		return r[7:0];
	endfunction

	// floored (p-k) mod 95, plus 32
	function automatic logic [7:0] shift_dec(input logic [7:0] p, input logic [7:0] k);
		logic signed [9:0] d;
		logic signed [9:0] r;
		d = $signed({{2{p[7]}}, p}) - $signed({{2{k[7]}}, k});
		if (d >= LANG_MOD + LANG_MOD)
			r = d - (LANG_MOD + LANG_MOD);
		else if (d >= LANG_MOD)
			r = d - LANG_MOD;
		else if (d >= 10'sd0)
			r = d;
		else if (d >= -LANG_MOD)
			r = d + LANG_MOD;
		else if (d >= -(LANG_MOD + LANG_MOD))
			r = d + (LANG_MOD + LANG_MOD);
		else
			r = d + LANG_MOD * 10'sd3;
		r = r + LANG_FIRST;
		return r[7:0];
	endfunction

endpackage

>>> src/vxc_cipher_core.sv
module vxc_cipher_core import vxc_pkg::*; #(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  cfg_t       cfg,
	input  key_pos_t   pos,
	input  logic       message_start,
	input  logic [7:0] data_byte,
	output logic [7:0] result_byte,
	output key_pos_t   pos_next
);

	logic [4:0] len_eff;
	logic [3:0] sp, xp;
	logic [3:0] s_idx, x_idx, s_nxt, x_nxt;
	logic [7:0] s_key, x_key;
	logic [7:0] enc_sh, enc_out, dec_x, dec_out;
	logic       enc_skip, dec_skip, shift_adv;

	// index to use now and the one after it; out-of-range falls back to byte 0
	function automatic logic [3:0] take_idx(input logic [3:0] p, input logic [4:0] len);
		return ({1'b0, p} < len) ? p : 4'd0;
	endfunction

	function automatic logic [3:0] next_idx(input logic [3:0] i, input logic [4:0] len);
		logic [4:0] n;
		n = {1'b0, i} + 5'd1;
		return (n >= len) ? 4'd0 : n[3:0];
	endfunction

	always_comb begin
		if (cfg.key_length == 5'd0)
			len_eff = 5'd1;
		else if (cfg.key_length > 5'(KEY_BYTES))
			len_eff = 5'(KEY_BYTES);
		else
			len_eff = cfg.key_length;
	end

	assign sp    = message_start ? 4'd0 : pos.shift_pos;
	assign xp    = message_start ? 4'd0 : pos.xor_pos;
	assign s_idx = take_idx(sp, len_eff);
	assign x_idx = take_idx(xp, len_eff);
	assign s_nxt = next_idx(s_idx, len_eff);
	assign x_nxt = next_idx(x_idx, len_eff);
	assign s_key = cfg.key[{s_idx, 3'b000} +: 8];
	assign x_key = cfg.key[{x_idx, 3'b000} +: 8];

	// encrypt: shift, then xor
	assign enc_skip = (data_byte == NEWLINE_BYTE) || (data_byte == EOF_BYTE);
	assign enc_sh   = (cfg.caesar_en && !enc_skip) ? shift_enc(data_byte, s_key) : data_byte;
	assign enc_out  = cfg.xor_en ? (enc_sh ^ x_key) : enc_sh;

	// decrypt: xor, then inverse shift
	assign dec_x    = cfg.xor_en ? (data_byte ^ x_key) : data_byte;
	assign dec_skip = (dec_x == NEWLINE_BYTE) || (dec_x == EOF_BYTE);
	assign dec_out  = (cfg.caesar_en && !dec_skip) ? shift_dec(dec_x, s_key) : dec_x;

	assign result_byte = cfg.decrypt ? dec_out : enc_out;
	assign shift_adv   = cfg.caesar_en && !(cfg.decrypt ? dec_skip : enc_skip);

	assign pos_next.shift_pos = shift_adv  ? s_nxt : sp;
	assign pos_next.xor_pos   = cfg.xor_en ? x_nxt : xp;

endmodule

>>> src/vigenere_xor_byte_cipher_unit.sv
// Byte stream cipher: an optional printable-ASCII Vigenere shift and an
// optional repeating-key XOR, keyed by up to KEY_BYTES bytes.
//
// Input channel (in_valid/in_ready): one message word per handshake,
// data_byte plus message_start, which restarts both key positions.
// Output channel (out_valid/out_ready): one result_byte word per input word,
// in order.
// Path: an accepted word waits in the input register (s1), then moves to
// the output register (s2) when it is free. Throughput: one word per cycle
// while out_ready is high; the cipher math is one short path from s1 to the
// result register, and the key positions update in the same cycle.
// Stall: when out_ready is low the result holds, and the input register
// still takes one more word; in_ready drops only when both are full.
// Config: APB port, 64-bit data, register i at byte address 8*i, pready tied
// high. Write only while the pipe is empty.
// Reset (arst_n low): both stages empty, key positions zero, key zero,
// key_length 1, shift on, XOR off, encrypt mode.
module vigenere_xor_byte_cipher_unit import vxc_pkg::*; #(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// APB config
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// input words
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              message_start,
	// output words
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        result_byte
);

	logic [63:0] key_lo_q, key_hi_q;
	logic [4:0]  key_len_q;
	logic        caesar_q, xor_q, decrypt_q;
	cfg_t        cfg;
	key_pos_t    pos_q, pos_next;

	logic        valid_s1, start_s1;
	logic [7:0]  data_s1;
	logic        valid_s2;
	logic [7:0]  result_s2;
	logic [7:0]  result_c;
	logic        s2_ready, advance, cfg_wr;
	logic [2:0]  reg_idx;

	// ---------------- configuration ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q  <= '0;
			key_hi_q  <= '0;
			key_len_q <= 5'd1;
			caesar_q  <= 1'b1;
			xor_q     <= 1'b0;
			decrypt_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_KEY_LO:  key_lo_q  <= pwdata;
				REG_KEY_HI:  key_hi_q  <= pwdata;
				REG_KEY_LEN: key_len_q <= pwdata[4:0];
				REG_CAESAR:  caesar_q  <= pwdata[0];
				REG_XOR:     xor_q     <= pwdata[0];
				REG_DECRYPT: decrypt_q <= pwdata[0];
				default: ;   // unmapped: dropped
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_KEY_LO:  prdata = key_lo_q;
			REG_KEY_HI:  prdata = key_hi_q;
			REG_KEY_LEN: prdata = {59'd0, key_len_q};
			REG_CAESAR:  prdata = {63'd0, caesar_q};
			REG_XOR:     prdata = {63'd0, xor_q};
			REG_DECRYPT: prdata = {63'd0, decrypt_q};
			default:     prdata = '0;
		endcase
	end

	assign cfg.key        = {key_hi_q, key_lo_q};
	assign cfg.key_length = key_len_q;
	assign cfg.caesar_en  = caesar_q;
	assign cfg.xor_en     = xor_q;
	assign cfg.decrypt    = decrypt_q;

	// ---------------- pipeline control ----------------
	// s2 is the output register; s1 moves into it whenever it is free or
	// being drained, so the key positions step once per word moved.
	assign s2_ready = !valid_s2 || out_ready;
	assign advance  = valid_s1 && s2_ready;
	assign in_ready = !valid_s1 || s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
			if (advance)
				pos_q <= pos_next;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_byte;
			start_s1 <= message_start;
		end
		if (advance)
			result_s2 <= result_c;
	end

	vxc_cipher_core #(
		.KEY_BYTES(KEY_BYTES)
	) u_core (
		.cfg          (cfg),
		.pos          (pos_q),
		.message_start(start_s1),
		.data_byte    (data_s1),
		.result_byte  (result_c),
		.pos_next     (pos_next)
	);

	assign out_valid   = valid_s2;
	assign result_byte = result_s2;

endmodule

>>> src/vxc_checker.sv
`include "vigenere_xor_byte_cipher_unit_macros.svh"

module vxc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [7:0]        result_byte
);

	// stalled result holds
	`VXC_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(result_byte), "result changed while stalled")

	// input backs up only when both stages are full and the output is stalled
	`VXC_ASSERT(a_ready_low, clk, arst_n, !in_ready |-> out_valid && !out_ready, "in_ready low with room in pipe")

	// accepted word reaches the output if the sink takes words while it sits in s1
	`VXC_ASSERT(a_latency, clk, arst_n, in_valid && in_ready ##1 out_ready |=> out_valid, "accepted word did not reach output")

	// nothing is shown while in reset
	`VXC_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !out_valid, "output valid during reset")

endmodule

bind vigenere_xor_byte_cipher_unit vxc_checker u_vxc_checker (.*);
